[hw/rtl/ipbp_pkg.sv]
// Shared types, constants and elaboration-time functions of the image point to board polar block.
package ipbp_pkg;

  typedef logic signed [31:0] cval_t;
  typedef logic [31:0] angle_t;

  localparam int GUARD = 12;
  localparam int TAB_LEN = 24;
  localparam int GAIN_FRAC = 30;
  localparam int SCALE_FRAC = 16;
  localparam int OFF_W = 22;
  localparam int DIST_W = 21;
  localparam int BEAR_W = 16;
  localparam int MM_W = 20;
  localparam int PROD_W = 54;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_FRAME_ANGLE = 2'd2;
  localparam logic [1:0] REG_MM_PER_PIXEL = 2'd3;

  localparam angle_t ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic angle_t quant_angle(angle_t a, int s);
    angle_t half;
    angle_t sum;
    if (s == 0) begin
      return a;
    end
    half = angle_t'(1) << (s - 1);
    sum = a + half;
    return (sum >> s) << s;
  endfunction

  function automatic logic [30:0] inv_gain_q30(int n);
    logic [63:0] k2;
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] part;
    k2 = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      k2 = k2 + (k2 >> (2 * i));
    end
    rem = k2;
    res = 64'd0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > rem) begin
        bitv = bitv >> 2;
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 64'd0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    num = (64'd1 << 60) + (res >> 1);
    quo = 64'd0;
    part = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[62:0], num[b]};
      if (part >= res) begin
        part = part - res;
        quo[b] = 1'b1;
      end
    end
    return quo[30:0];
  endfunction

  function automatic logic signed [OFF_W-1:0] sat_off(logic signed [25:0] v);
    if (v > 26'sd2097151) begin
      return 22'sd2097151;
    end else if (v < -26'sd2097152) begin
      return -22'sd2097152;
    end
    return v[OFF_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(logic signed [25:0] v);
    if (v < 26'sd0) begin
      return '0;
    end else if (v > 26'sd2097151) begin
      return 21'd2097151;
    end
    return v[DIST_W-1:0];
  endfunction

endpackage

[hw/rtl/ipbp_if.sv]
// Valid/ready channel interfaces for image points and board polar results.
interface ipbp_point_if;
  logic valid;
  logic ready;
  logic [15:0] point_x;
  logic [15:0] point_y;
  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface ipbp_result_if;
  logic valid;
  logic ready;
  logic signed [21:0] offset_x;
  logic signed [21:0] offset_y;
  logic [20:0] distance;
  logic signed [15:0] bearing;
  logic in_millimeters;
  modport source (output valid, output offset_x, output offset_y, output distance,
                  output bearing, output in_millimeters, input ready);
  modport sink (input valid, input offset_x, input offset_y, input distance,
                input bearing, input in_millimeters, output ready);
endinterface

[hw/rtl/ipbp_cordic.sv]
// Unrolled CORDIC pipeline, one registered micro-rotation per stage, rotation or vectoring mode.
module ipbp_cordic #(
  parameter int STAGES = 16,
  parameter bit VECTOR = 1'b0,
  parameter int ANGLE_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  ipbp_pkg::cval_t  x_in,
  input  ipbp_pkg::cval_t  y_in,
  input  ipbp_pkg::angle_t z_in,
  output ipbp_pkg::cval_t  x_out,
  output ipbp_pkg::cval_t  y_out,
  output ipbp_pkg::angle_t z_out
);
  import ipbp_pkg::*;

  cval_t xr [STAGES];
  cval_t yr [STAGES];
  angle_t zr [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam angle_t T = quant_angle(ATAN_TAB[i], 32 - ANGLE_BITS);
    cval_t xi;
    cval_t yi;
    angle_t zi;
    logic pos;
    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
    end
    assign pos = VECTOR ? yi[31] : !zi[31];
    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          xr[i] <= xi - (yi >>> i);
          yr[i] <= yi + (xi >>> i);
          zr[i] <= zi - T;
        end else begin
          xr[i] <= xi + (yi >>> i);
          yr[i] <= yi - (xi >>> i);
          zr[i] <= zi + T;
        end
      end
    end
  end

  assign x_out = xr[STAGES-1];
  assign y_out = yr[STAGES-1];
  assign z_out = zr[STAGES-1];
endmodule

[hw/rtl/ipbp_gain.sv]
// Two-stage removal of the CORDIC gain: Q30 multiply, then round half up.
module ipbp_gain #(
  parameter logic [30:0] KINV = 31'd652032874
) (
  input  logic          clk,
  input  logic          en,
  input  ipbp_pkg::cval_t v_in,
  output ipbp_pkg::cval_t v_out
);
  import ipbp_pkg::*;

  localparam logic signed [31:0] KM = {1'b0, KINV};

  logic signed [62:0] prod;
  logic signed [62:0] rnd;

  assign rnd = prod + (63'sd1 <<< (GAIN_FRAC - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 63'(v_in) * 63'(KM);
      v_out <= rnd[GAIN_FRAC+31:GAIN_FRAC];
    end
  end
endmodule

[hw/rtl/image_point_to_board_polar.sv]
// Top level of the image point to board polar block: configuration, pipeline and output.
//
// Image points (unsigned 12.4) enter on the points channel; each gives exactly one item
// on the results channel: board offsets with up positive, distance and bearing, in 1/16
// pixel or, when mm_per_pixel is nonzero, 1/16 mm units, saturated to the field ranges.
// The four registers are written over the APB port at byte addresses 0, 4, 8 and 12
// and are read back there; write them only while no item is in flight.
// The pipeline holds an input register, the rotation CORDIC, its gain multiply, a
// vectoring input register, the vectoring CORDIC, its gain multiply, the scaling
// multiply and the rounding and saturation output register, in that order.
// One item is accepted every cycle unless the output stalls; the pipeline is fully unrolled.
// When the receiver holds ready low with a result waiting, the whole pipeline holds
// and points.ready falls, so nothing is lost or repeated.
// Synchronous reset clears the registers and all stage valid bits.
module image_point_to_board_polar #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  ipbp_point_if.sink          points,
  ipbp_result_if.source       results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ipbp_pkg::*;

  localparam int N = CORDIC_STAGES;
  localparam int LAT = 2 * N + 8;
  localparam int QS = 32 - ANGLE_BITS;
  localparam logic [30:0] KINV = inv_gain_q30(N);

  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [15:0] frame_angle;
  logic [MM_W-1:0] mm_per_pixel;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      frame_angle <= '0;
      mm_per_pixel <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ORIGIN_X: origin_x <= pwdata[15:0];
        REG_ORIGIN_Y: origin_y <= pwdata[15:0];
        REG_FRAME_ANGLE: frame_angle <= pwdata[15:0];
        REG_MM_PER_PIXEL: mm_per_pixel <= pwdata[MM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ORIGIN_X: prdata = {16'd0, origin_x};
      REG_ORIGIN_Y: prdata = {16'd0, origin_y};
      REG_FRAME_ANGLE: prdata = {16'd0, frame_angle};
      REG_MM_PER_PIXEL: prdata = {12'd0, mm_per_pixel};
      default: prdata = '0;
    endcase
  end

  logic adv;
  logic [LAT-1:0] vld;

  assign adv = !vld[LAT-1] || results.ready;
  assign points.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], points.valid};
    end
  end

  // Input stage: origin removal and a half-turn fold so the CORDIC sees at most 90 degrees.
  logic signed [16:0] ddx;
  logic signed [16:0] ddy;
  cval_t dx0;
  cval_t dy0;
  angle_t a_q;
  logic flip;

  assign ddx = $signed({1'b0, points.point_x}) - $signed({1'b0, origin_x});
  assign ddy = $signed({1'b0, points.point_y}) - $signed({1'b0, origin_y});
  assign dx0 = cval_t'(ddx) <<< GUARD;
  assign dy0 = cval_t'(ddy) <<< GUARD;
  assign a_q = quant_angle(32'd0 - {frame_angle, 16'd0}, QS);
  assign flip = (a_q[31:30] == 2'b01) || (a_q[31:30] == 2'b10);

  cval_t rx0;
  cval_t ry0;
  angle_t rz0;

  always_ff @(posedge clk) begin
    if (adv) begin
      rx0 <= flip ? -dx0 : dx0;
      ry0 <= flip ? -dy0 : dy0;
      rz0 <= flip ? a_q + 32'h8000_0000 : a_q;
    end
  end

  cval_t rot_x;
  cval_t rot_y;
  angle_t rot_z;

  ipbp_cordic #(.STAGES(N), .VECTOR(1'b0), .ANGLE_BITS(ANGLE_BITS)) u_rot (
    .clk(clk), .en(adv), .x_in(rx0), .y_in(ry0), .z_in(rz0),
    .x_out(rot_x), .y_out(rot_y), .z_out(rot_z)
  );

  cval_t gx;
  cval_t gy;

  ipbp_gain #(.KINV(KINV)) u_gain_x (.clk(clk), .en(adv), .v_in(rot_x), .v_out(gx));
  ipbp_gain #(.KINV(KINV)) u_gain_y (.clk(clk), .en(adv), .v_in(rot_y), .v_out(gy));

  cval_t dyg;
  assign dyg = -gy;

  // Vectoring input stage, offsets travel alongside the vectoring pipeline.
  cval_t vx0;
  cval_t vy0;
  angle_t vz0;
  cval_t dlx [N+3];
  cval_t dly [N+3];

  always_ff @(posedge clk) begin
    if (adv) begin
      vx0 <= gx[31] ? -gx : gx;
      vy0 <= gx[31] ? -dyg : dyg;
      vz0 <= gx[31] ? 32'h8000_0000 : 32'd0;
      dlx[0] <= gx;
      dly[0] <= dyg;
      for (int k = 1; k < N + 3; k++) begin
        dlx[k] <= dlx[k-1];
        dly[k] <= dly[k-1];
      end
    end
  end

  cval_t vec_x;
  cval_t vec_y;
  angle_t vec_z;

  ipbp_cordic #(.STAGES(N), .VECTOR(1'b1), .ANGLE_BITS(ANGLE_BITS)) u_vec (
    .clk(clk), .en(adv), .x_in(vx0), .y_in(vy0), .z_in(vz0),
    .x_out(vec_x), .y_out(vec_y), .z_out(vec_z)
  );

  cval_t rg;

  ipbp_gain #(.KINV(KINV)) u_gain_r (.clk(clk), .en(adv), .v_in(vec_x), .v_out(rg));

  // Scaling: pixel units use a factor of one in Q16 so both cases share the rounding.
  angle_t zd [2];
  angle_t zs;
  logic signed [21:0] mult;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [PROD_W-1:0] pr;
  logic signed [PROD_W-1:0] rpx;
  logic signed [PROD_W-1:0] rpy;
  logic signed [PROD_W-1:0] rpr;
  logic [DIST_W-1:0] dist_n;
  angle_t zsum;

  assign mult = (mm_per_pixel == '0) ? 22'sd65536 : $signed({2'b00, mm_per_pixel});

  always_ff @(posedge clk) begin
    if (adv) begin
      zd[0] <= vec_z;
      zd[1] <= zd[0];
      zs <= zd[1];
      px <= PROD_W'(dlx[N+2]) * PROD_W'(mult);
      py <= PROD_W'(dly[N+2]) * PROD_W'(mult);
      pr <= PROD_W'(rg) * PROD_W'(mult);
    end
  end

  localparam int RS = GUARD + SCALE_FRAC;

  assign rpx = px + (PROD_W'(1) <<< (RS - 1));
  assign rpy = py + (PROD_W'(1) <<< (RS - 1));
  assign rpr = pr + (PROD_W'(1) <<< (RS - 1));
  assign dist_n = sat_dist(rpr[RS+25:RS]);
  assign zsum = zs + 32'h0000_8000;

  logic signed [OFF_W-1:0] o_x;
  logic signed [OFF_W-1:0] o_y;
  logic [DIST_W-1:0] o_d;
  logic [BEAR_W-1:0] o_b;
  logic o_mm;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x <= sat_off(rpx[RS+25:RS]);
      o_y <= sat_off(rpy[RS+25:RS]);
      o_d <= dist_n;
      o_b <= (dist_n == '0) ? '0 : zsum[31:16];
      o_mm <= (mm_per_pixel != '0);
    end
  end

  assign results.valid = vld[LAT-1];
  assign results.offset_x = o_x;
  assign results.offset_y = o_y;
  assign results.distance = o_d;
  assign results.bearing = $signed(o_b);
  assign results.in_millimeters = o_mm;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("Stage valid bits moved while the output was stalled.");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready |=> vld[0])
    else $error("Accepted item did not enter the first stage.");

  a_zero_bearing: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.distance == '0 |-> results.bearing == '0)
    else $error("Nonzero bearing with zero distance.");
endmodule
